[rtl/core/pcpf_pkg.sv]
// shared constants and helpers for the point cloud packet framer
package pcpf_pkg;

	// width of point counts and packet counters
	localparam int CNT_W = 21;
	// width of one framed word and of one raw float word
	localparam int WORD_W = 32;

	// default packet sizing limits
	localparam int MAX_PER_PACKET_DEF = 2000;
	localparam int MIN_POINTS_DEF = 50;

	// framing words
	localparam logic [WORD_W-1:0] SYNC_WORD = 32'h0000_55aa;
	localparam logic [WORD_W-1:0] TRAILER_WORD = 32'h0000_aa55;

	// smallest packet divisor
	localparam logic [CNT_W-1:0] FIRST_DIVISOR = 21'd5;

	// byte reversal of a raw float word
	function automatic logic [WORD_W-1:0] swap_bytes(input logic [WORD_W-1:0] v);
		swap_bytes = {v[7:0], v[15:8], v[23:16], v[31:24]};
	endfunction

endpackage

[rtl/core/point_cloud_packet_framer_top.sv]
// point cloud packet framer: sizes packets per cloud and frames points into words
//
// Input channel (in_valid/in_ready) carries one point per item: four raw float words.
// Output channel (out_valid/out_ready) carries one framed word per item, with
// end_of_packet on the trailer word and last_of_run on the final word of a point.
// total_points is written through cfg_we/cfg_wdata and is latched when a cloud starts.
// At the first point of a cloud, packet sizing runs three 21-step divisions on a
// shared restoring divider (none for small clouds).
// After that a point goes out as its output words: 4 data words,
// plus 5 header words at packet start and one trailer at packet end.
// The word sequencer emits one word per cycle, while the receiver takes them, into a single output register.
// in_ready is high only while the sequencer is idle; the next point can be taken
// while the last word of the previous one still waits in the output register.
// A stalled receiver holds the output register and the sequencer waits with it.
// Points of clouds of MIN_POINTS or fewer are taken with no output.
// Reset (arst_n low) clears all counters, the configuration register and the output valid.
module point_cloud_packet_framer_top #(
	parameter int MAX_PER_PACKET = pcpf_pkg::MAX_PER_PACKET_DEF,
	parameter int MIN_POINTS = pcpf_pkg::MIN_POINTS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         cfg_we,
	input  logic [pcpf_pkg::CNT_W-1:0]   cfg_wdata,
	input  logic                         in_valid,
	output logic                         in_ready,
	input  logic [pcpf_pkg::WORD_W-1:0]  x_bits,
	input  logic [pcpf_pkg::WORD_W-1:0]  y_bits,
	input  logic [pcpf_pkg::WORD_W-1:0]  z_bits,
	input  logic [pcpf_pkg::WORD_W-1:0]  intensity_bits,
	output logic                         out_valid,
	input  logic                         out_ready,
	output logic [pcpf_pkg::WORD_W-1:0]  word,
	output logic                         end_of_packet,
	output logic                         last_of_run
);

	localparam int CW = pcpf_pkg::CNT_W;
	localparam int WW = pcpf_pkg::WORD_W;
	localparam int SCW = $clog2(CW + 1);

	localparam logic [CW-1:0] DIV_FIRST = CW'(MAX_PER_PACKET + 1);
	localparam logic [CW-1:0] MIN_PTS = CW'(MIN_POINTS);
	localparam logic [SCW-1:0] STEPS = SCW'(CW);

	// sequencer states
	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_DIV1 = 3'd1;
	localparam logic [2:0] S_DIV2 = 3'd2;
	localparam logic [2:0] S_DIV3 = 3'd3;
	localparam logic [2:0] S_PREP = 3'd4;
	localparam logic [2:0] S_EMIT = 3'd5;

	// word slots of one point
	localparam logic [3:0] W_SYNC0 = 4'd0;
	localparam logic [3:0] W_SYNC1 = 4'd1;
	localparam logic [3:0] W_PKT_ID = 4'd2;
	localparam logic [3:0] W_PKT_CNT = 4'd3;
	localparam logic [3:0] W_PKT_PTS = 4'd4;
	localparam logic [3:0] W_X = 4'd5;
	localparam logic [3:0] W_Y = 4'd6;
	localparam logic [3:0] W_Z = 4'd7;
	localparam logic [3:0] W_INT = 4'd8;
	localparam logic [3:0] W_TRAIL = 4'd9;

	logic [2:0]    state_q;
	logic [CW-1:0] total_points_q;
	logic [CW-1:0] points_left_q;
	logic [CW-1:0] per_packet_q;
	logic [CW-1:0] packet_total_q;
	logic [CW-1:0] packet_number_q;
	logic [CW-1:0] points_in_cur_q;
	logic [CW-1:0] pkt_points_q;
	logic          cloud_started_q;
	logic          trailer_q;
	logic [3:0]    slot_q;
	logic [WW-1:0] x_q;
	logic [WW-1:0] y_q;
	logic [WW-1:0] z_q;
	logic [WW-1:0] int_q;

	// shared divider registers
	logic [CW-1:0]  dvd_q;
	logic [CW-1:0]  dsr_q;
	logic [CW-1:0]  rem_q;
	logic [SCW-1:0] step_q;

	// output register
	logic          out_valid_q;
	logic [WW-1:0] word_q;
	logic          eop_q;
	logic          last_q;

	// divider step
	logic [CW:0]   div_trial;
	logic [CW:0]   div_diff;
	logic          div_qbit;
	logic          div_done;
	logic [CW-1:0] div_rem_next;

	assign div_trial = {rem_q, dvd_q[CW-1]};
	assign div_diff = div_trial - {1'b0, dsr_q};
	assign div_qbit = ~div_diff[CW];
	assign div_rem_next = div_qbit ? div_diff[CW-1:0] : div_trial[CW-1:0];
	assign div_done = (step_q == STEPS);

	// results of finished divisions
	logic [CW-1:0] div1_p;
	logic [CW-1:0] div2_per;
	logic [CW-1:0] div3_total;

	always_comb begin
		div1_p = dvd_q + CW'(1);
		if (div1_p < pcpf_pkg::FIRST_DIVISOR) begin
			div1_p = pcpf_pkg::FIRST_DIVISOR;
		end
		div2_per = (dvd_q == '0) ? CW'(1) : dvd_q;
		div3_total = dvd_q + CW'(rem_q != '0);
	end

	// packet bookkeeping for the current point
	logic          hdr_needed;
	logic [CW-1:0] pts_eff;

	assign hdr_needed = (points_in_cur_q == '0);
	always_comb begin
		if (hdr_needed) begin
			pts_eff = (points_left_q < per_packet_q) ? points_left_q : per_packet_q;
		end else begin
			pts_eff = points_in_cur_q;
		end
	end

	// word for the current slot
	logic [WW-1:0] slot_word;
	logic          slot_last;
	logic          out_free;

	always_comb begin
		unique case (slot_q)
			W_SYNC0:   slot_word = pcpf_pkg::SYNC_WORD;
			W_SYNC1:   slot_word = pcpf_pkg::SYNC_WORD;
			W_PKT_ID:  slot_word = WW'(packet_number_q);
			W_PKT_CNT: slot_word = WW'(packet_total_q);
			W_PKT_PTS: slot_word = WW'(pkt_points_q);
			W_X:       slot_word = pcpf_pkg::swap_bytes(x_q);
			W_Y:       slot_word = pcpf_pkg::swap_bytes(y_q);
			W_Z:       slot_word = pcpf_pkg::swap_bytes(z_q);
			W_INT:     slot_word = pcpf_pkg::swap_bytes(int_q);
			default:   slot_word = pcpf_pkg::TRAILER_WORD;
		endcase
	end

	assign slot_last = (slot_q == W_TRAIL) || ((slot_q == W_INT) && !trailer_q);
	assign out_free = !out_valid_q || out_ready;

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			total_points_q <= '0;
		end else if (cfg_we) begin
			total_points_q <= cfg_wdata;
		end
	end

	// sequencer, divider and packet state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			points_left_q <= '0;
			per_packet_q <= '0;
			packet_total_q <= '0;
			packet_number_q <= '0;
			points_in_cur_q <= '0;
			pkt_points_q <= '0;
			cloud_started_q <= 1'b0;
			dvd_q <= '0;
			dsr_q <= '0;
			rem_q <= '0;
			step_q <= '0;
			slot_q <= W_SYNC0;
			trailer_q <= 1'b0;
		end else begin
			unique case (state_q)
				S_IDLE: begin
					if (in_valid) begin
						if (cloud_started_q) begin
							state_q <= S_PREP;
						end else if (total_points_q != '0) begin
							cloud_started_q <= 1'b1;
							points_left_q <= total_points_q;
							packet_number_q <= '0;
							points_in_cur_q <= '0;
							if (total_points_q <= MIN_PTS) begin
								per_packet_q <= '0;
								packet_total_q <= '0;
								state_q <= S_PREP;
							end else begin
								dvd_q <= total_points_q;
								dsr_q <= DIV_FIRST;
								rem_q <= '0;
								step_q <= '0;
								state_q <= S_DIV1;
							end
						end
					end
				end
				S_DIV1, S_DIV2, S_DIV3: begin
					if (!div_done) begin
						rem_q <= div_rem_next;
						dvd_q <= {dvd_q[CW-2:0], div_qbit};
						step_q <= step_q + SCW'(1);
					end else begin
						rem_q <= '0;
						step_q <= '0;
						dvd_q <= points_left_q;
						priority case (state_q)
							S_DIV1: begin
								dsr_q <= div1_p;
								state_q <= S_DIV2;
							end
							S_DIV2: begin
								per_packet_q <= div2_per;
								dsr_q <= div2_per;
								state_q <= S_DIV3;
							end
							default: begin
								packet_total_q <= div3_total;
								state_q <= S_PREP;
							end
						endcase
					end
				end
				S_PREP: begin
					points_left_q <= points_left_q - CW'(1);
					if (points_left_q == CW'(1)) begin
						cloud_started_q <= 1'b0;
					end
					if (per_packet_q == '0) begin
						state_q <= S_IDLE;
					end else begin
						if (hdr_needed) begin
							packet_number_q <= packet_number_q + CW'(1);
						end
						pkt_points_q <= pts_eff;
						points_in_cur_q <= pts_eff - CW'(1);
						trailer_q <= (pts_eff == CW'(1));
						slot_q <= hdr_needed ? W_SYNC0 : W_X;
						state_q <= S_EMIT;
					end
				end
				S_EMIT: begin
					if (out_free) begin
						if (slot_last) begin
							state_q <= S_IDLE;
						end else begin
							slot_q <= slot_q + 4'd1;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// point capture
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && in_valid) begin
			x_q <= x_bits;
			y_q <= y_bits;
			z_q <= z_bits;
			int_q <= intensity_bits;
		end
	end

	// output register valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (state_q == S_EMIT && out_free) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// output register payload
	always_ff @(posedge clk) begin
		if (state_q == S_EMIT && out_free) begin
			word_q <= slot_word;
			eop_q <= (slot_q == W_TRAIL);
			last_q <= slot_last;
		end
	end

	assign in_ready = (state_q == S_IDLE);
	assign out_valid = out_valid_q;
	assign word = word_q;
	assign end_of_packet = eop_q;
	assign last_of_run = last_q;

endmodule
